/* rtl/sem_pkg.sv */
package sem_pkg;

    localparam int PIX_W      = 8;
    localparam int MAG_W      = 8;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 16;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int MAG_LIMIT     = 255;
    localparam int MIN_DIM       = 3;
    localparam int IMG_DIM_RESET = 1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 4'd0,
        REG_IMAGE_HEIGHT = 4'd1
    } t_reg_idx;

endpackage

/* rtl/sem_if.sv */
// Pixel channel: one grayscale pixel per transfer.
interface sem_pix_if;
    import sem_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// Result channel: one edge magnitude per transfer.
interface sem_res_if;
    import sem_pkg::*;

    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] magnitude;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic             frame_last;

    modport source (output valid, output magnitude, output out_col, output out_row,
                    output frame_last, input ready);
    modport sink   (input valid, input magnitude, input out_col, input out_row,
                    input frame_last, output ready);
endinterface

// Register write channel.
interface sem_cfg_if;
    import sem_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/sem_ram.sv */
module sem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/sobel_edge_magnitude_stream_core.sv */
// Pipeline: input register (stage A), then result register. The pixel that completes a window
//   is held in stage A while a stalled result fills the output, then its result is registered.
// Throughput: one pixel per cycle unless a stalled result holds stage A; the line buffer RAM is
//   read once at pixel transfer, written once when that pixel leaves the compute stage: one RAM slot.
// Reset (i_rst_n low, synchronous): clears counters, window, pipeline valids and sets the
//   image size to 1024 x 1024. Line buffers are not cleared (no clearing pass).
module sobel_edge_magnitude_stream_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sem_cfg_if.sink     i_cfg,
    sem_pix_if.sink     i_pix,
    sem_res_if.source   o_res
);
    import sem_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1; // column / RAM address bits
    localparam int DW = IMG_H_W;                                 // dimension compare width
    localparam int SW = PIXEL_BITS + 2;                          // one kernel half-sum
    localparam int MW = PIXEL_BITS + 3;                          // |Gx| + |Gy|

    // ---------------------------------------------------------------- config
    logic [IMG_W_W-1:0] r_img_w;
    logic [IMG_H_W-1:0] r_img_h;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= IMG_W_W'(IMG_DIM_RESET);
            r_img_h <= IMG_H_W'(IMG_DIM_RESET);
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_IMAGE_WIDTH:  r_img_w <= i_cfg.data[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: r_img_h <= i_cfg.data[IMG_H_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------- raster position
    logic [CW-1:0]      r_col;
    logic [ROW_W-1:0]   r_row;
    logic [DW-1:0]      w_in;
    logic [DW-1:0]      w_eff;
    logic [DW-1:0]      h_eff;
    logic [DW-1:0]      col_ext;
    logic               col_end;
    logic               row_end;
    logic               in_fire;
    logic               a_fire;

    // Effective size: width clamped to MIN_DIM..MAX_WIDTH, height to at least MIN_DIM.
    always_comb begin
        w_in = DW'(r_img_w);
        if (w_in < DW'(MIN_DIM)) begin
            w_eff = DW'(MIN_DIM);
        end else if (w_in > DW'(MAX_WIDTH)) begin
            w_eff = DW'(MAX_WIDTH);
        end else begin
            w_eff = w_in;
        end
        h_eff   = (r_img_h < IMG_H_W'(MIN_DIM)) ? DW'(MIN_DIM) : DW'(r_img_h);
        col_ext = DW'(r_col);
        // ">=" so a counter left past a shrunk size wraps on the next pixel
        col_end = col_ext >= (w_eff - DW'(1));
        row_end = DW'(r_row) >= (h_eff - DW'(1));
    end

    assign in_fire = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_fire) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // --------------------------------------------------------- pixel input
    logic [PIXEL_BITS-1:0] pix_in;

    generate
        if (PIXEL_BITS >= PIX_W) begin : g_pix_ext
            assign pix_in = PIXEL_BITS'(i_pix.pixel);
        end else begin : g_pix_cut
            assign pix_in = i_pix.pixel[PIXEL_BITS-1:0];
        end
    endgenerate

    // ------------------------------------------------- stage A (input reg)
    // Holds the accepted pixel while the line buffer read for its column
    // comes back from the RAM.
    logic                  r_a_valid;
    logic [PIXEL_BITS-1:0] r_a_pix;
    logic [CW-1:0]         r_a_col;
    logic                  r_a_int;   // window centred on an interior pixel
    logic                  r_a_last;
    logic [COL_W-1:0]      r_a_ocol;
    logic [ROW_W-1:0]      r_a_orow;

    logic                  r_o_valid;

    // Border pixels leave stage A without needing room at the output.
    assign a_fire      = r_a_valid && (!r_a_int || !r_o_valid || o_res.ready);
    assign i_pix.ready = !r_a_valid || a_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_fire) begin
            r_a_valid <= 1'b1;
        end else if (a_fire) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_pix  <= pix_in;
            r_a_col  <= r_col;
            r_a_int  <= (col_ext >= DW'(2)) && (r_row >= ROW_W'(2));
            r_a_last <= col_end && row_end;
            r_a_ocol <= COL_W'(col_ext - DW'(1));
            r_a_orow <= r_row - ROW_W'(1);
        end
    end

    // ---------------------------------------------------------- line buffers
    // One RAM word per column: {row above, two rows above}. Read is issued at
    // pixel transfer, write-back when the pixel leaves stage A. The same column
    // is not read again for at least MIN_DIM pixels, so no bypass is needed.
    logic [2*PIXEL_BITS-1:0] line_rd;
    logic [PIXEL_BITS-1:0]   top;
    logic [PIXEL_BITS-1:0]   mid;
    logic [PIXEL_BITS-1:0]   bot;

    assign mid = line_rd[2*PIXEL_BITS-1:PIXEL_BITS];
    assign top = line_rd[PIXEL_BITS-1:0];
    assign bot = r_a_pix;

    sem_ram #(
        .WIDTH (2 * PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (a_fire),
        .i_waddr (r_a_col),
        .i_wdata ({bot, mid}),
        .i_re    (in_fire),
        .i_raddr (r_col),
        .o_rdata (line_rd)
    );

    // --------------------------------------------------------------- window
    // r_win[0..2]: column-2 (top, mid, bottom); r_win[3..5]: column-1.
    logic [PIXEL_BITS-1:0] r_win [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (a_fire) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top;
            r_win[4] <= mid;
            r_win[5] <= bot;
        end
    end

    // -------------------------------------------------------------- kernels
    // Each gradient is a difference of two non-negative 1-2-1 sums, so the
    // absolute value is a compare and one subtract; no signed math needed.
    logic [SW-1:0]    gx_pos, gx_neg, gy_pos, gy_neg;
    logic [SW-1:0]    gx_abs, gy_abs;
    logic [MW-1:0]    mag;
    logic [MAG_W-1:0] mag_sat;

    always_comb begin
        gx_pos = SW'(top) + (SW'(mid) << 1) + SW'(bot);
        gx_neg = SW'(r_win[0]) + (SW'(r_win[1]) << 1) + SW'(r_win[2]);
        gy_pos = SW'(r_win[2]) + (SW'(r_win[5]) << 1) + SW'(bot);
        gy_neg = SW'(r_win[0]) + (SW'(r_win[3]) << 1) + SW'(top);
        gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
        gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
        mag    = MW'(gx_abs) + MW'(gy_abs);
        mag_sat = (32'(mag) > 32'(MAG_LIMIT)) ? MAG_W'(MAG_LIMIT) : MAG_W'(mag);
    end

    // -------------------------------------------------------- result register
    logic [MAG_W-1:0] r_o_mag;
    logic [COL_W-1:0] r_o_col;
    logic [ROW_W-1:0] r_o_row;
    logic             r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (a_fire && r_a_int) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire && r_a_int) begin
            r_o_mag  <= mag_sat;
            r_o_col  <= r_a_ocol;
            r_o_row  <= r_a_orow;
            r_o_last <= r_a_last;
        end
    end

    assign o_res.valid      = r_o_valid;
    assign o_res.magnitude  = r_o_mag;
    assign o_res.out_col    = r_o_col;
    assign o_res.out_row    = r_o_row;
    assign o_res.frame_last = r_o_last;

endmodule

/* rtl/sem_checker.sv */
module sem_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [sem_pkg::MAG_W-1:0] i_out_magnitude,
    input logic [sem_pkg::COL_W-1:0] i_out_col,
    input logic [sem_pkg::ROW_W-1:0] i_out_row,
    input logic                  i_out_frame_last
);
    import sem_pkg::*;

    // Result register empties on reset.
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_magnitude) && $stable(i_out_col) &&
            $stable(i_out_row) && $stable(i_out_frame_last))
        else $error("stalled result changed");

    // Only interior pixels produce results.
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_col != '0) && (i_out_row != '0))
        else $error("result on a border pixel");

    // A fresh result follows a pixel transfer through stage A and the result register.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result without matching pixel transfer");

endmodule

bind sobel_edge_magnitude_stream_core sem_checker u_sem_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_pix.valid),
    .i_in_ready       (i_pix.ready),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_out_magnitude  (o_res.magnitude),
    .i_out_col        (o_res.out_col),
    .i_out_row        (o_res.out_row),
    .i_out_frame_last (o_res.frame_last)
);

/* bench/sobel_edge_magnitude_stream_core_test.sv */
module sobel_edge_magnitude_stream_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sem_pkg::*;

    // Line buffer depth of the instance, and the pipeline depth from pixel transfer
    // to result valid.
    localparam int LINE_DEPTH   = 1024;
    localparam int PIPE_DEPTH   = 2;
    // Cycles without any transfer before the run is declared hung.
    localparam int IDLE_LIMIT   = 2000;
    // Width of the priming frame: covers every column the random part can reach.
    localparam int PRIME_WIDTH  = 96;
    // Pixels in the randomized part, after the directed frames and the priming frame.
    localparam int RANDOM_ITEMS = 560;

    // One edge result as it leaves the block.
    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } t_edge_res;

    typedef enum bit {STEP_CFG, STEP_PIX} t_step_kind;

    // One row of the directed stimulus: a register write or a pixel, with a hand-typed
    // result where it is obvious.
    typedef struct {
        t_step_kind            kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
        logic [PIX_W-1:0]      pixel;
        bit                    typed;
        t_edge_res             want;
    } t_dir_row;

    logic clk = 1'b0;
    logic rst_n;

    sem_cfg_if cfg_ch ();
    sem_pix_if pix_ch ();
    sem_res_if res_ch ();

    sobel_edge_magnitude_stream_core #(
        .MAX_WIDTH  (LINE_DEPTH),
        .PIXEL_BITS (PIX_W)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_pix   (pix_ch),
        .o_res   (res_ch)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: image size, scan position, 3x3 window, line buffers.
    // Line buffers start at zero; the stimulus never lets a never-written entry reach a
    // result, so the block's undefined power-up contents never matter.
    // ------------------------------------------------------------------
    logic [IMG_W_W-1:0] cur_width;
    logic [IMG_H_W-1:0] cur_height;
    logic [COL_W-1:0]   pos_col;
    logic [ROW_W-1:0]   pos_row;
    bit   [PIX_W-1:0]   win [6];          // 0..2: column c-2 (top, mid, bot); 3..5: column c-1
    bit   [PIX_W-1:0]   row1_buf [LINE_DEPTH]; // row just above
    bit   [PIX_W-1:0]   row2_buf [LINE_DEPTH]; // two rows above

    t_edge_res pending_edges [$];

    // Hand-typed expectation for the pixel being sent, used instead of the predictor.
    bit        typed_valid = 1'b0;
    t_edge_res typed_res;

    int error_count  = 0;
    int pixels_sent  = 0;
    int regs_written = 0;
    int edges_seen   = 0;
    int frames_done  = 0;
    int burst_left   = 0;
    int stall_left   = 0;
    int stall_mode   = 0;
    int idle_cycles  = 0;

    // Advances the predictor by one pixel. Returns 1 when the window is centered on an
    // interior pixel, with the expected result in res.
    function automatic bit sobel_window_step(input logic [PIX_W-1:0] px, output t_edge_res res);
        int w, h, tl, ml, bl, tc, bc, tr, mr, br, gx, gy, mag;
        bit col_end, row_end, fires;
        // Clamp to what the hardware can hold: width 3..depth, height at least 3
        w = (cur_width < MIN_DIM) ? MIN_DIM : (cur_width > LINE_DEPTH ? LINE_DEPTH : cur_width);
        h = (cur_height < MIN_DIM) ? MIN_DIM : cur_height;
        tr = row2_buf[pos_col];
        mr = row1_buf[pos_col];
        br = px;
        col_end = (pos_col >= w - 1);
        row_end = (pos_row >= h - 1);
        fires = (pos_col >= 2) && (pos_row >= 2);
        res = '0;
        if (fires) begin
            tl = win[0];
            ml = win[1];
            bl = win[2];
            tc = win[3];
            bc = win[5];
            gx = (tr + 2 * mr + br) - (tl + 2 * ml + bl);
            gy = (bl + 2 * bc + br) - (tl + 2 * tc + tr);
            mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
            if (mag > MAG_LIMIT) mag = MAG_LIMIT;
            res.magnitude = mag[MAG_W-1:0];
            res.col       = pos_col - 1'b1;
            res.row       = pos_row - 1'b1;
            res.last      = col_end && row_end;
        end
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = tr[PIX_W-1:0];
        win[4] = mr[PIX_W-1:0];
        win[5] = px;
        row2_buf[pos_col] = mr[PIX_W-1:0];
        row1_buf[pos_col] = px;
        // A counter already at or past the last position wraps on this pixel
        if (col_end) begin
            pos_col = '0;
            pos_row = row_end ? '0 : pos_row + 1'b1;
        end else begin
            pos_col = pos_col + 1'b1;
        end
        return fires;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: everything is sampled at the rising edge. Result transfers are
    // checked first, then register writes and pixel transfers update the predictor.
    // A pixel's result passes the block's input and result registers before it leaves, so the order is safe.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : scoreboard
        t_edge_res want;
        t_edge_res got;
        bit        fires;
        if (!rst_n) begin
            cur_width  = IMG_W_W'(IMG_DIM_RESET);
            cur_height = IMG_H_W'(IMG_DIM_RESET);
            pos_col    = '0;
            pos_row    = '0;
            foreach (win[i]) win[i] = '0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got = {res_ch.magnitude, res_ch.out_col, res_ch.out_row, res_ch.frame_last};
                if (pending_edges.size() == 0) begin
                    $error("edge result with nothing pending: col %0d row %0d",
                           got.col, got.row);
                    error_count++;
                end else begin
                    want = pending_edges.pop_front();
                    check_field("magnitude", want.magnitude, got.magnitude);
                    check_field("out_col", want.col, got.col);
                    check_field("out_row", want.row, got.row);
                    check_field("frame_last", want.last, got.last);
                    edges_seen++;
                    if (want.last) frames_done++;
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                // Unmapped indexes are accepted and dropped
                case (cfg_ch.index)
                    REG_IMAGE_WIDTH:  cur_width  = cfg_ch.data[IMG_W_W-1:0];
                    REG_IMAGE_HEIGHT: cur_height = cfg_ch.data[IMG_H_W-1:0];
                    default: ;
                endcase
            end
            if (pix_ch.valid && pix_ch.ready) begin
                fires = sobel_window_step(pix_ch.pixel, want);
                if (typed_valid) pending_edges.push_back(typed_res);
                else if (fires) pending_edges.push_back(want);
            end
        end
    end

    // Watchdog: any transfer on any channel counts as progress.
    always @(posedge clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results pending",
                     IDLE_LIMIT, pending_edges.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side back-pressure: segments of always-ready, light and heavy random
    // stalls, and a periodic 3-of-7 stall.
    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 120);
        end
        stall_left--;
        case (stall_mode)
            0:       res_ch.ready <= 1'b1;
            1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
            2:       res_ch.ready <= ($urandom_range(0, 1) != 0);
            default: res_ch.ready <= ((stall_left % 7) >= 3);
        endcase
    end

    // ------------------------------------------------------------------
    // Drivers. Every task is entered just after a falling edge and returns just
    // after one, so the scoreboard has already seen the last rising edge.
    // ------------------------------------------------------------------

    // Pixel source: bursts of random length, random gaps between them, and now and
    // then a long burst with no idling at all.
    task automatic send_pixel(input logic [PIX_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 250)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                pix_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= value;
        do begin
            @(posedge clk);
        end while (!pix_ch.ready);
        pixels_sent++;
        @(negedge clk);
    endtask

    // Register write; valid drops for a cycle after each transfer.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        do begin
            @(posedge clk);
        end while (!cfg_ch.ready);
        regs_written++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Stop the pixel stream and let the pipeline empty. Border pixels leave nothing
    // in the queue, so allow the pipeline depth on top of an empty queue.
    task automatic drain();
        pix_ch.valid <= 1'b0;
        while (pending_edges.size() != 0) @(negedge clk);
        repeat (PIPE_DEPTH + 2) @(negedge clk);
    endtask

    // Pixel content: full random, black/white only, a ramp with a little noise,
    // and low-contrast noise that stays clear of saturation.
    function automatic logic [PIX_W-1:0] next_pixel(input int style);
        case (style)
            0:       return PIX_W'($urandom_range(0, (1 << PIX_W) - 1));
            1:       return $urandom_range(0, 1) ? '1 : '0;
            2:       return PIX_W'(pos_col * 9 + pos_row * 5 + $urandom_range(0, 3));
            default: return PIX_W'(16 + $urandom_range(0, 24));
        endcase
    endfunction

    // Width value with junk above the register's 11 bits; sometimes below the
    // minimum so the clamp is hit.
    function automatic logic [CFG_DATA_W-1:0] pick_width(input int top);
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 7))
            0:       v[IMG_W_W-1:0] = IMG_W_W'($urandom_range(0, MIN_DIM - 1));
            1:       v[IMG_W_W-1:0] = IMG_W_W'($urandom_range(MIN_DIM, top * 4));
            default: v[IMG_W_W-1:0] = IMG_W_W'($urandom_range(MIN_DIM, top));
        endcase
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_height(input int top);
        if ($urandom_range(0, 7) == 0) return CFG_DATA_W'($urandom_range(0, MIN_DIM - 1));
        return CFG_DATA_W'($urandom_range(MIN_DIM, top));
    endfunction

    // Send pixels until the scan position is at column 0 of the given row.
    task automatic run_to_row(input int row_stop, input int style);
        do begin
            send_pixel(next_pixel(style));
        end while (!(pos_col == 0 && pos_row == row_stop));
    endtask

    // ------------------------------------------------------------------
    // Directed frames, 3x3 with both sizes clamped up from below:
    //   - step edge, dark left and bright right column: |Gx| = 1020, saturates
    //   - flat white frame: both gradients cancel to zero
    // Each frame has exactly one interior pixel, whose result is flagged as the frame's last.
    // ------------------------------------------------------------------
    t_dir_row directed_rows [0:19] = '{
        '{STEP_CFG, REG_IMAGE_WIDTH,  16'hF801, 8'd0, 1'b0, '0},  // width 1 -> 3
        '{STEP_CFG, REG_IMAGE_HEIGHT, 16'h0000, 8'd0, 1'b0, '0},  // height 0 -> 3
        '{STEP_PIX, '0, '0, 8'd0,   1'b0, '0},
        '{STEP_PIX, '0, '0, 8'd0,   1'b0, '0},
        '{STEP_PIX, '0, '0, 8'd255, 1'b0, '0},
        '{STEP_PIX, '0, '0, 8'd0,   1'b0, '0},
        '{STEP_PIX, '0, '0, 8'd0,   1'b0, '0},
        '{STEP_PIX, '0, '0, 8'd255, 1'b0, '0},
        '{STEP_PIX, '0, '0, 8'd0,   1'b0, '0},
        '{STEP_PIX, '0, '0, 8'd0,   1'b0, '0},
        '{STEP_PIX, '0, '0, 8'd255, 1'b1, '{8'd255, 10'd1, 16'd1, 1'b1}},
        '{STEP_PIX, '0, '0, 8'd255, 1'b0, '0},
        '{STEP_PIX, '0, '0, 8'd255, 1'b0, '0},
        '{STEP_PIX, '0, '0, 8'd255, 1'b0, '0},
        '{STEP_PIX, '0, '0, 8'd255, 1'b0, '0},
        '{STEP_PIX, '0, '0, 8'd255, 1'b0, '0},
        '{STEP_PIX, '0, '0, 8'd255, 1'b0, '0},
        '{STEP_PIX, '0, '0, 8'd255, 1'b0, '0},
        '{STEP_PIX, '0, '0, 8'd255, 1'b0, '0},
        '{STEP_PIX, '0, '0, 8'd255, 1'b1, '{8'd0, 10'd1, 16'd1, 1'b1}}
    };

    initial begin
        int style;
        int shape;
        int stop_at;
        rst_n        = 1'b0;
        pix_ch.valid = 1'b0;
        pix_ch.pixel = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == STEP_CFG) begin
                write_reg(directed_rows[i].index, directed_rows[i].value);
            end else begin
                typed_valid = directed_rows[i].typed;
                typed_res   = directed_rows[i].want;
                send_pixel(directed_rows[i].pixel);
                typed_valid = 1'b0;
            end
        end

        // Priming frame, height 2 clamps to 3. It writes every line buffer column that
        // the random part can reach (widths up to 4 x 24), so later mid-frame width
        // changes never read an entry that was never written.
        drain();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(PRIME_WIDTH));
        write_reg(REG_IMAGE_HEIGHT, 16'd2);
        run_to_row(0, 0);

        // Random part. Three shapes of work, each starting from an empty pipeline:
        //   - whole small frames after a size change at the frame boundary
        //   - a tall frame cut short by lowering the height mid-frame
        //   - a width or height change in the middle of a frame
        stop_at = pixels_sent + RANDOM_ITEMS;
        while (pixels_sent < stop_at) begin
            style = $urandom_range(0, 3);
            shape = $urandom_range(0, 9);
            drain();
            if (shape <= 5) begin
                if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_WIDTH, pick_width(16));
                if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_HEIGHT, pick_height(8));
                if ($urandom_range(0, 5) == 0) begin
                    write_reg(CFG_IDX_W'($urandom_range(REG_IMAGE_HEIGHT + 1,
                                                        (1 << CFG_IDX_W) - 1)),
                              CFG_DATA_W'($urandom));
                end
                repeat ($urandom_range(1, 2)) run_to_row(0, style);
            end else if (shape <= 7) begin
                write_reg(REG_IMAGE_WIDTH, pick_width(12));
                write_reg(REG_IMAGE_HEIGHT, $urandom_range(0, 1) ? 16'hFFFF
                                           : CFG_DATA_W'($urandom_range(16'h0100, 16'hFFFE)));
                run_to_row($urandom_range(3, 6), style);
                drain();
                // At or past the new last row, the frame ends with the current row
                write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(MIN_DIM, 8)));
                run_to_row(0, style);
            end else begin
                write_reg(REG_IMAGE_WIDTH, pick_width(16));
                write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(MIN_DIM, 8)));
                repeat ($urandom_range(1, 40)) send_pixel(next_pixel(style));
                drain();
                // Shrinking below the current column wraps it on the next pixel
                if ($urandom_range(0, 1)) write_reg(REG_IMAGE_WIDTH, pick_width(24));
                else write_reg(REG_IMAGE_HEIGHT, pick_height(8));
                run_to_row(0, style);
            end
        end

        drain();
        $display("Covered %0d pixels and %0d register writes; checked %0d edge results",
                 pixels_sent, regs_written, edges_seen);
        $display("across %0d completed frames, clamped sizes and mid-frame size changes",
                 frames_done);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/sem_pkg.sv
rtl/sem_if.sv
rtl/sem_ram.sv
rtl/sobel_edge_magnitude_stream_core.sv
rtl/sem_checker.sv
bench/sobel_edge_magnitude_stream_core_test.sv
